### rtl/irq_paced_fifo_drain_sequencer_assert.svh
// Assertion macros shared by the sequencer RTL.
`ifndef IRQ_PACED_FIFO_DRAIN_SEQUENCER_ASSERT_SVH
`define IRQ_PACED_FIFO_DRAIN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IPFDS_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPFDS_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ipfds_pkg.sv
`timescale 1ns / 1ps

package ipfds_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_W = 4;

    localparam int STATUS_LSB = 9;
    localparam int STATUS_W = 3;

    localparam logic [7:0] READ_OVERHEAD = 8'd2;
    localparam logic [7:0] CLEAR_LEN = 8'd4;
    localparam logic [7:0] CMD_LEN = 8'd2;
    localparam logic [7:0] RESP_LEN = 8'd6;
    localparam logic [7:0] MAX_LEN = 8'd255;

    localparam logic [7:0] DRAIN_BYTES_RESET = 8'd126;
    localparam logic [2:0] OK_CODE_RESET = 3'd0;
    localparam logic [2:0] DATA_CODE_RESET = 3'd1;

    localparam logic [1:0] CFG_DRAIN_BYTES = 2'd0;
    localparam logic [1:0] CFG_OK_CODE = 2'd1;
    localparam logic [1:0] CFG_DATA_CODE = 2'd2;

    localparam logic [2:0] FN_IRQ_EDGE = 3'd0;
    localparam logic [2:0] FN_BUSY_FALL = 3'd1;
    localparam logic [2:0] FN_FRAME_DONE = 3'd2;
    localparam logic [2:0] FN_RELEASE = 3'd3;

    localparam logic [2:0] FR_NONE = 3'd0;
    localparam logic [2:0] FR_FIFO_READ = 3'd1;
    localparam logic [2:0] FR_CLEAR_FIFO = 3'd2;
    localparam logic [2:0] FR_IRQ_CMD = 3'd3;
    localparam logic [2:0] FR_IRQ_RESP = 3'd4;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_STARTED = 3'd1;
    localparam logic [2:0] EV_RESTARTED = 3'd2;
    localparam logic [2:0] EV_CHAIN_ERR = 3'd3;
    localparam logic [2:0] EV_SKIP_FULL = 3'd4;
    localparam logic [2:0] EV_SKIP_BUSY = 3'd5;
    localparam logic [2:0] EV_FINISHED = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_WAIT_READ  = 4'd1,
        PH_READ       = 4'd2,
        PH_WAIT_CLEAR = 4'd3,
        PH_CLEAR      = 4'd4,
        PH_WAIT_CMD   = 4'd5,
        PH_CMD        = 4'd6,
        PH_WAIT_RESP  = 4'd7,
        PH_RESP       = 4'd8
    } phase_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        busy_level;
        logic        line_high;
        logic        frame_ok;
        logic [15:0] stat_word;
        logic        abort_req;
        logic        loop_drain_active;
        logic        loop_drain_terminal;
        logic        bus_in_flight;
        logic        post_accepted;
    } evt_item_t;

    typedef struct packed {
        logic [2:0] post_frame;
        logic [7:0] frame_length;
        logic [3:0] fill_index;
        logic       raise_nss;
        logic       busy_irq_armed;
        logic [3:0] chain_phase;
        logic       parse_ready;
        logic [3:0] parse_index;
        logic [2:0] event_code;
    } res_item_t;

    typedef struct packed {
        logic [7:0] drain_bytes;
        logic [2:0] ok_status_code;
        logic [2:0] data_status_code;
    } cfg_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == SLOT_W'(NUM_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic phase_t phase_inc(input phase_t p);
        return phase_t'(p + 4'd1);
    endfunction

    function automatic logic [2:0] frame_of(input phase_t p);
        logic [2:0] r;
        case (p)
            PH_WAIT_READ:  r = FR_FIFO_READ;
            PH_WAIT_CLEAR: r = FR_CLEAR_FIFO;
            PH_WAIT_CMD:   r = FR_IRQ_CMD;
            PH_WAIT_RESP:  r = FR_IRQ_RESP;
            default:       r = FR_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] frame_len(input phase_t p, input logic [7:0] drain);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, drain} + {1'b0, READ_OVERHEAD};
        case (p)
            PH_WAIT_READ:  r = sum[8] ? MAX_LEN : sum[7:0];
            PH_WAIT_CLEAR: r = CLEAR_LEN;
            PH_WAIT_CMD:   r = CMD_LEN;
            PH_WAIT_RESP:  r = RESP_LEN;
            default:       r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ipfds_cfg.sv
`timescale 1ns / 1ps

module ipfds_cfg
    import ipfds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg
);

    logic [7:0] drain_bytes_reg;
    logic [2:0] ok_code_reg;
    logic [2:0] data_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_bytes_reg <= DRAIN_BYTES_RESET;
            ok_code_reg     <= OK_CODE_RESET;
            data_code_reg   <= DATA_CODE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_DRAIN_BYTES: drain_bytes_reg <= wr_data;
                CFG_OK_CODE:     ok_code_reg <= wr_data[2:0];
                CFG_DATA_CODE:   data_code_reg <= wr_data[2:0];
                default:         ;
            endcase
        end
    end

    assign cfg.drain_bytes      = drain_bytes_reg;
    assign cfg.ok_status_code   = ok_code_reg;
    assign cfg.data_status_code = data_code_reg;

endmodule

### rtl/ipfds_step.sv
`timescale 1ns / 1ps

module ipfds_step
    import ipfds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  evt_item_t item,
    input  cfg_t      cfg,
    output res_item_t result
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [SLOT_W-1:0]     fill_reg;
    logic [SLOT_W-1:0]     fill_next;
    logic [SLOT_W-1:0]     parse_reg;
    logic [SLOT_W-1:0]     parse_next;
    logic [NUM_SLOTS-1:0]  slot_reg;
    logic [NUM_SLOTS-1:0]  slot_next;
    logic                  armed_reg;
    logic                  armed_next;

    logic [STATUS_W-1:0]   status_code;
    logic                  stat_good;
    logic                  filled_f;
    logic                  is_wait;
    logic                  is_fly;
    logic                  fly_fail;
    logic                  loop_blocks;
    logic                  edge_start;
    logic                  resp_ok;
    logic                  restart;

    logic [2:0]            frame_out;
    logic [7:0]            len_out;
    logic                  nss_out;
    logic [2:0]            event_out;

    assign status_code = item.stat_word[STATUS_LSB +: STATUS_W];
    assign stat_good   = (status_code == cfg.ok_status_code) ||
                         (status_code == cfg.data_status_code);
    assign filled_f    = slot_reg[fill_reg];
    assign is_wait     = (phase_reg == PH_WAIT_READ) || (phase_reg == PH_WAIT_CLEAR) ||
                         (phase_reg == PH_WAIT_CMD) || (phase_reg == PH_WAIT_RESP);
    assign is_fly      = (phase_reg == PH_READ) || (phase_reg == PH_CLEAR) ||
                         (phase_reg == PH_CMD);
    assign fly_fail    = !item.frame_ok || ((phase_reg == PH_READ) && !stat_good);
    assign loop_blocks = item.loop_drain_active &&
                         (item.bus_in_flight || item.loop_drain_terminal);
    assign edge_start  = (item.func == FN_IRQ_EDGE) && !item.abort_req && !filled_f &&
                         (phase_reg == PH_IDLE) && !loop_blocks;
    assign resp_ok     = (item.func == FN_FRAME_DONE) && !item.abort_req &&
                         (phase_reg == PH_RESP) && item.frame_ok && stat_good;
    assign restart     = resp_ok && item.line_high && !filled_f;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        parse_next = parse_reg;
        slot_next  = slot_reg;
        armed_next = armed_reg;
        case (item.func)
            FN_IRQ_EDGE:
            begin
                if (edge_start)
                begin
                    if (item.busy_level)
                    begin
                        phase_next = PH_WAIT_READ;
                        armed_next = 1'b1;
                    end
                    else if (item.post_accepted)
                    begin
                        phase_next = PH_READ;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        armed_next = 1'b0;
                    end
                end
            end
            FN_BUSY_FALL:
            begin
                armed_next = 1'b0;
                if (item.abort_req)
                begin
                    phase_next = PH_IDLE;
                end
                else if (is_wait)
                begin
                    phase_next = item.post_accepted ? phase_inc(phase_reg) : PH_IDLE;
                end
            end
            FN_FRAME_DONE:
            begin
                if (item.abort_req)
                begin
                    armed_next = 1'b0;
                    phase_next = PH_IDLE;
                end
                else if (is_fly)
                begin
                    if (fly_fail)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (phase_reg == PH_READ)
                        begin
                            slot_next[fill_reg] = 1'b1;
                            fill_next = slot_inc(fill_reg);
                        end
                        phase_next = phase_inc(phase_reg);
                        armed_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_RESP)
                begin
                    if (!resp_ok)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    else if (restart)
                    begin
                        if (item.busy_level)
                        begin
                            phase_next = PH_WAIT_READ;
                            armed_next = 1'b1;
                        end
                        else if (item.post_accepted)
                        begin
                            phase_next = PH_READ;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            armed_next = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            FN_RELEASE:
            begin
                slot_next[parse_reg] = 1'b0;
                parse_next = slot_inc(parse_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        frame_out = FR_NONE;
        len_out   = 8'd0;
        nss_out   = 1'b0;
        event_out = EV_NONE;
        case (item.func)
            FN_IRQ_EDGE:
            begin
                if (!item.abort_req)
                begin
                    if (filled_f)
                    begin
                        event_out = EV_SKIP_FULL;
                    end
                    else if (phase_reg == PH_IDLE)
                    begin
                        if (loop_blocks)
                        begin
                            event_out = EV_SKIP_BUSY;
                        end
                        else
                        begin
                            event_out = EV_STARTED;
                            if (!item.busy_level)
                            begin
                                if (item.post_accepted)
                                begin
                                    frame_out = FR_FIFO_READ;
                                    len_out   = frame_len(PH_WAIT_READ, cfg.drain_bytes);
                                end
                                else
                                begin
                                    event_out = EV_CHAIN_ERR;
                                    nss_out   = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            FN_BUSY_FALL:
            begin
                if (item.abort_req)
                begin
                    nss_out = 1'b1;
                end
                else if (is_wait)
                begin
                    if (item.post_accepted)
                    begin
                        frame_out = frame_of(phase_reg);
                        len_out   = frame_len(phase_reg, cfg.drain_bytes);
                    end
                    else
                    begin
                        event_out = EV_CHAIN_ERR;
                        nss_out   = 1'b1;
                    end
                end
            end
            FN_FRAME_DONE:
            begin
                if (item.abort_req)
                begin
                    nss_out = 1'b1;
                end
                else if (is_fly)
                begin
                    nss_out = 1'b1;
                    if (fly_fail)
                    begin
                        event_out = EV_CHAIN_ERR;
                    end
                end
                else if (phase_reg == PH_RESP)
                begin
                    nss_out = 1'b1;
                    if (!resp_ok)
                    begin
                        event_out = EV_CHAIN_ERR;
                    end
                    else if (restart)
                    begin
                        event_out = EV_RESTARTED;
                        if (!item.busy_level)
                        begin
                            if (item.post_accepted)
                            begin
                                frame_out = FR_FIFO_READ;
                                len_out   = frame_len(PH_WAIT_READ, cfg.drain_bytes);
                            end
                            else
                            begin
                                event_out = EV_CHAIN_ERR;
                            end
                        end
                    end
                    else
                    begin
                        event_out = EV_FINISHED;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            parse_reg <= '0;
            slot_reg  <= '0;
            armed_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            parse_reg <= parse_next;
            slot_reg  <= slot_next;
            armed_reg <= armed_next;
        end
    end

    assign result.post_frame     = frame_out;
    assign result.frame_length   = len_out;
    assign result.fill_index     = IDX_W'(fill_next);
    assign result.raise_nss      = nss_out;
    assign result.busy_irq_armed = armed_next;
    assign result.chain_phase    = phase_next;
    assign result.parse_ready    = slot_next[parse_next];
    assign result.parse_index    = IDX_W'(parse_next);
    assign result.event_code     = event_out;

endmodule

### rtl/irq_paced_fifo_drain_sequencer.sv
`timescale 1ns / 1ps
// An accepted event is held in the input register; its result goes into the result register and drives res.
// Throughput: one event per cycle; the input register and result register pass one item
// per cycle, and evt_ready falls only while a result is held by res_ready low.
// Reset: rst_n clears the chain to idle, both ring indices, all slot flags and the BUSY arm,
// and loads the configuration registers with 126, 0 and 1; no clearing pass is needed.

`include "irq_paced_fifo_drain_sequencer_assert.svh"

module irq_paced_fifo_drain_sequencer
    import ipfds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_valid,
    output logic       evt_ready,
    input  evt_item_t  evt,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic      in_valid_reg;
    evt_item_t in_item_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;
    logic      advance;
    cfg_t      cfg;
    res_item_t step_result;

    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign evt_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ipfds_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ipfds_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_valid && evt_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            in_item_reg <= evt;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    `IPFDS_ASSERT_SAME(a_stall_only_on_full, clk, rst_n, !evt_ready,
        res_valid && !res_ready, "Input stalled without a held result.")
    `IPFDS_ASSERT_NEXT(a_step_gives_result, clk, rst_n, advance, res_valid,
        "Processed transaction produced no result.")
    `IPFDS_ASSERT_SAME(a_post_has_length, clk, rst_n, res_valid && (res.post_frame != FR_NONE),
        res.frame_length != 8'd0, "Posted frame with zero length.")
    `IPFDS_ASSERT_SAME(a_post_sets_phase, clk, rst_n, res_valid && (res.post_frame != FR_NONE),
        res.chain_phase == {res.post_frame, 1'b0}, "Posted frame not in flight.")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ipfds_pkg::*;

    localparam logic [2:0] FN_IDLE_TICK = 3'd4;
    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT = 14;
    localparam int ITEMS_PER_SETTING = 150;

    class drain_scoreboard;
        logic [7:0] drain_bytes;
        logic [2:0] ok_code;
        logic [2:0] data_code;
        phase_t phase;
        logic [3:0] fill_ptr;
        logic [3:0] parse_ptr;
        logic filled [NUM_SLOTS];
        logic busy_armed;
        res_item_t step_res;
        res_item_t expected_q[$];
        int errors;

        function new();
            drain_bytes = DRAIN_BYTES_RESET;
            ok_code = OK_CODE_RESET;
            data_code = DATA_CODE_RESET;
            phase = PH_IDLE;
            fill_ptr = '0;
            parse_ptr = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                filled[i] = 1'b0;
            end
            busy_armed = 1'b0;
            errors = 0;
        endfunction

        function void set_register(input logic [1:0] idx, input logic [7:0] value);
            case (idx)
                CFG_DRAIN_BYTES: drain_bytes = value;
                CFG_OK_CODE:     ok_code = value[2:0];
                CFG_DATA_CODE:   data_code = value[2:0];
                default:         ;
            endcase
        endfunction

        function int slot_of(input logic [3:0] idx);
            return (idx < NUM_SLOTS) ? int'(idx) : 0;
        endfunction

        function logic status_good(input logic [15:0] stat);
            logic [2:0] code;
            code = stat[STATUS_LSB +: STATUS_W];
            return (code == ok_code) || (code == data_code);
        endfunction

        function logic in_wait(input phase_t p);
            return (p == PH_WAIT_READ) || (p == PH_WAIT_CLEAR) || (p == PH_WAIT_CMD)
                || (p == PH_WAIT_RESP);
        endfunction

        function void abort_chain();
            busy_armed = 1'b0;
            phase = PH_IDLE;
            step_res.raise_nss = 1'b1;
        endfunction

        function void post_waiting_frame(input logic accepted);
            logic [2:0] fr;
            logic [7:0] len;
            logic [8:0] sum;
            sum = {1'b0, drain_bytes} + 9'd2;
            case (phase)
                PH_WAIT_READ:
                begin
                    fr = FR_FIFO_READ;
                    len = (sum > 9'd255) ? 8'd255 : sum[7:0];
                end
                PH_WAIT_CLEAR:
                begin
                    fr = FR_CLEAR_FIFO;
                    len = 8'd4;
                end
                PH_WAIT_CMD:
                begin
                    fr = FR_IRQ_CMD;
                    len = 8'd2;
                end
                PH_WAIT_RESP:
                begin
                    fr = FR_IRQ_RESP;
                    len = 8'd6;
                end
                default:
                begin
                    return;
                end
            endcase
            if (!accepted)
            begin
                step_res.event_code = EV_CHAIN_ERR;
                abort_chain();
                return;
            end
            step_res.post_frame = fr;
            step_res.frame_length = len;
            phase = phase_t'(phase + 4'd1);
        endfunction

        function void start_drain(input logic busy, input logic accepted);
            phase = PH_WAIT_READ;
            if (!busy)
            begin
                post_waiting_frame(accepted);
            end
            else
            begin
                busy_armed = 1'b1;
            end
        endfunction

        function void note_event(input evt_item_t e);
            int f;
            int p;
            f = slot_of(fill_ptr);
            step_res = '0;
            case (e.func)
                FN_IRQ_EDGE:
                begin
                    if (!e.abort_req)
                    begin
                        if (filled[f])
                        begin
                            step_res.event_code = EV_SKIP_FULL;
                        end
                        else if (phase == PH_IDLE)
                        begin
                            if (e.loop_drain_active
                                && (e.bus_in_flight || e.loop_drain_terminal))
                            begin
                                step_res.event_code = EV_SKIP_BUSY;
                            end
                            else
                            begin
                                step_res.event_code = EV_STARTED;
                                start_drain(e.busy_level, e.post_accepted);
                            end
                        end
                    end
                end
                FN_BUSY_FALL:
                begin
                    busy_armed = 1'b0;
                    if (e.abort_req)
                    begin
                        abort_chain();
                    end
                    else if (in_wait(phase))
                    begin
                        post_waiting_frame(e.post_accepted);
                    end
                end
                FN_FRAME_DONE:
                begin
                    if (e.abort_req)
                    begin
                        abort_chain();
                    end
                    else if ((phase == PH_READ) || (phase == PH_CLEAR) || (phase == PH_CMD))
                    begin
                        if (!e.frame_ok || (phase == PH_READ && !status_good(e.stat_word)))
                        begin
                            step_res.event_code = EV_CHAIN_ERR;
                            abort_chain();
                        end
                        else
                        begin
                            if (phase == PH_READ)
                            begin
                                filled[f] = 1'b1;
                                fill_ptr = 4'((f + 1) % NUM_SLOTS);
                            end
                            phase = phase_t'(phase + 4'd1);
                            busy_armed = 1'b1;
                            step_res.raise_nss = 1'b1;
                        end
                    end
                    else if (phase == PH_RESP)
                    begin
                        if (!e.frame_ok || !status_good(e.stat_word))
                        begin
                            step_res.event_code = EV_CHAIN_ERR;
                            abort_chain();
                        end
                        else
                        begin
                            step_res.raise_nss = 1'b1;
                            if (e.line_high && !filled[f])
                            begin
                                step_res.event_code = EV_RESTARTED;
                                start_drain(e.busy_level, e.post_accepted);
                            end
                            else
                            begin
                                phase = PH_IDLE;
                                step_res.event_code = EV_FINISHED;
                            end
                        end
                    end
                end
                FN_RELEASE:
                begin
                    p = slot_of(parse_ptr);
                    filled[p] = 1'b0;
                    parse_ptr = 4'((p + 1) % NUM_SLOTS);
                end
                default:
                begin
                end
            endcase
            step_res.fill_index = fill_ptr;
            step_res.busy_irq_armed = busy_armed;
            step_res.chain_phase = phase;
            step_res.parse_ready = filled[slot_of(parse_ptr)];
            step_res.parse_index = parse_ptr;
            expected_q.push_back(step_res);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(input string name, input int got, input int want);
            if (got != want)
            begin
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
            end
        endtask

        task check_result(input res_item_t got);
            res_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with no pending transaction");
                return;
            end
            want = expected_q.pop_front();
            compare_field("post_frame", got.post_frame, want.post_frame);
            compare_field("frame_length", got.frame_length, want.frame_length);
            compare_field("fill_index", got.fill_index, want.fill_index);
            compare_field("raise_nss", got.raise_nss, want.raise_nss);
            compare_field("busy_irq_armed", got.busy_irq_armed, want.busy_irq_armed);
            compare_field("chain_phase", got.chain_phase, want.chain_phase);
            compare_field("parse_ready", got.parse_ready, want.parse_ready);
            compare_field("parse_index", got.parse_index, want.parse_index);
            compare_field("event_code", got.event_code, want.event_code);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_ready;
    evt_item_t evt = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_item_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    drain_scoreboard sb = new();
    logic steady = 1'b0;
    int cycles = 0;

    irq_paced_fifo_drain_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            sb.check_result(res);
        end
    end

    task automatic send_event(input evt_item_t item);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt <= item;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (!evt_ready)
        begin
            @(posedge clk);
        end
        sb.note_event(item);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        evt_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_cfg(input logic [7:0] drain, input logic [2:0] okc,
                               input logic [2:0] datac);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx[0] = CFG_DRAIN_BYTES;
        idx[1] = CFG_OK_CODE;
        idx[2] = CFG_DATA_CODE;
        val[0] = drain;
        val[1] = {5'd0, okc};
        val[2] = {5'd0, datac};
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            sb.set_register(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic evt_item_t plain(input logic [2:0] code);
        evt_item_t e;
        e = '0;
        e.func = code;
        e.frame_ok = 1'b1;
        e.stat_word[STATUS_LSB +: STATUS_W] = sb.ok_code;
        e.post_accepted = 1'b1;
        return e;
    endfunction

    function automatic evt_item_t random_event();
        evt_item_t e;
        int roll;
        e.busy_level = 1'($urandom_range(1));
        e.line_high = 1'($urandom_range(1));
        e.frame_ok = ($urandom_range(99) < 90);
        e.stat_word = 16'($urandom);
        if ($urandom_range(99) < 85)
        begin
            e.stat_word[STATUS_LSB +: STATUS_W] = $urandom_range(1) ? sb.ok_code : sb.data_code;
        end
        e.abort_req = ($urandom_range(99) < 4);
        e.loop_drain_active = ($urandom_range(99) < 20);
        e.loop_drain_terminal = 1'($urandom_range(1));
        e.bus_in_flight = 1'($urandom_range(1));
        e.post_accepted = ($urandom_range(99) < 93);
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            e.func = 3'($urandom_range(7));
        end
        else if (roll < 20)
        begin
            e.func = FN_RELEASE;
        end
        else if (sb.phase == PH_IDLE)
        begin
            e.func = FN_IRQ_EDGE;
        end
        else if (sb.in_wait(sb.phase))
        begin
            e.func = FN_BUSY_FALL;
        end
        else
        begin
            e.func = FN_FRAME_DONE;
        end
        return e;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_event(random_event());
        wait_drained();
    endtask

    initial
    begin
        evt_item_t e;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(plain(FN_RELEASE));
        send_event(plain(FN_IDLE_TICK));
        send_event(plain(FN_UNUSED));
        send_event(plain(FN_BUSY_FALL));
        send_event(plain(FN_FRAME_DONE));
        e = plain(FN_IRQ_EDGE);
        e.abort_req = 1'b1;
        send_event(e);
        e = plain(FN_IRQ_EDGE);
        e.loop_drain_active = 1'b1;
        e.bus_in_flight = 1'b1;
        send_event(e);
        e = plain(FN_IRQ_EDGE);
        e.loop_drain_active = 1'b1;
        e.loop_drain_terminal = 1'b1;
        send_event(e);
        e = plain(FN_IRQ_EDGE);
        e.loop_drain_active = 1'b1;
        send_event(e);
        send_event(plain(FN_IRQ_EDGE));
        e = plain(FN_FRAME_DONE);
        e.stat_word = 16'h0000;
        send_event(e);
        send_event(plain(FN_BUSY_FALL));
        send_event(plain(FN_FRAME_DONE));
        send_event(plain(FN_BUSY_FALL));
        send_event(plain(FN_FRAME_DONE));
        send_event(plain(FN_BUSY_FALL));
        e = plain(FN_FRAME_DONE);
        e.line_high = 1'b1;
        e.busy_level = 1'b1;
        e.stat_word[STATUS_LSB +: STATUS_W] = sb.data_code;
        send_event(e);
        e = plain(FN_BUSY_FALL);
        e.post_accepted = 1'b0;
        send_event(e);
        e = plain(FN_IRQ_EDGE);
        e.post_accepted = 1'b0;
        send_event(e);
        e = plain(FN_IRQ_EDGE);
        e.busy_level = 1'b1;
        send_event(e);
        e = plain(FN_BUSY_FALL);
        e.abort_req = 1'b1;
        send_event(e);
        send_event(plain(FN_IRQ_EDGE));
        e = plain(FN_FRAME_DONE);
        e.stat_word = 16'hFFFF;
        send_event(e);
        send_event(plain(FN_IRQ_EDGE));
        e = plain(FN_FRAME_DONE);
        e.frame_ok = 1'b0;
        send_event(e);
        send_event(plain(FN_IRQ_EDGE));
        e = plain(FN_FRAME_DONE);
        e.abort_req = 1'b1;
        send_event(e);

        run_random(ITEMS_PER_SETTING);
        program_cfg(8'd1, 3'd7, 3'd6);
        steady <= 1'b1;
        run_random(ITEMS_PER_SETTING);
        steady <= 1'b0;
        program_cfg(8'd253, 3'd3, 3'd3);
        run_random(ITEMS_PER_SETTING);
        program_cfg(8'd255, 3'd0, 3'd7);
        run_random(ITEMS_PER_SETTING);
        program_cfg(8'd0, 3'd5, 3'd2);
        run_random(ITEMS_PER_SETTING);

        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
